// ----- sv/pbla_pkg.sv -----
package pbla_pkg;

  localparam int LEN_BITS   = 41;
  localparam int AREA_BITS  = 50;
  localparam int CROSS_BITS = 64;

  typedef struct packed {
    logic first;
    logic last;
  } ctl_t;

endpackage

// ----- sv/pbla_front.sv -----
module pbla_front #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] x_in,
  input  logic signed [COORD_BITS-1:0] y_in,
  input  logic                         last_in,
  output logic                         q_valid,
  input  logic                         q_take,
  output logic signed [COORD_BITS-1:0] q_x,
  output logic signed [COORD_BITS-1:0] q_y,
  output pbla_pkg::ctl_t               q_ctl
);

  logic                         start_r;
  logic                         q_valid_r;
  logic signed [COORD_BITS-1:0] q_x_r;
  logic signed [COORD_BITS-1:0] q_y_r;
  pbla_pkg::ctl_t               q_ctl_r;
  logic                         acc;

  assign full    = q_valid_r && !q_take;
  assign acc     = push && !full;
  assign q_valid = q_valid_r;
  assign q_x     = q_x_r;
  assign q_y     = q_y_r;
  assign q_ctl   = q_ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= 1'b1;
      q_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        start_r   <= last_in;
        q_valid_r <= 1'b1;
      end else if (q_take) begin
        q_valid_r <= 1'b0;
      end
    end
    if (acc) begin
      q_x_r         <= x_in;
      q_y_r         <= y_in;
      q_ctl_r.first <= start_r;
      q_ctl_r.last  <= last_in;
    end
  end

endmodule

// ----- sv/pbla_back.sv -----
module pbla_back #(
  parameter int COORD_BITS = 24,
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_take,
  input  logic signed [COORD_BITS-1:0] q_x,
  input  logic signed [COORD_BITS-1:0] q_y,
  input  pbla_pkg::ctl_t               q_ctl,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS-1:0] min_x,
  output logic signed [COORD_BITS-1:0] max_x,
  output logic signed [COORD_BITS-1:0] min_y,
  output logic signed [COORD_BITS-1:0] max_y,
  output logic [pbla_pkg::LEN_BITS-1:0]  total_length,
  output logic [pbla_pkg::AREA_BITS-1:0] twice_area,
  output logic                         clockwise,
  output logic                         closed,
  output logic [COUNT_BITS-1:0]        point_count
);

  localparam int DB = COORD_BITS + 1;
  localparam int SB = 2 * DB + 1;
  localparam int RB = DB + 1;
  localparam int PB = 2 * COORD_BITS;
  localparam int IB = $clog2(RB + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [pbla_pkg::LEN_BITS-1:0] LMAX = '1;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_SQRT, S_CLOSE, S_OUT} state_t;

  state_t state_r;
  logic signed [COORD_BITS-1:0] fx_r, fy_r, px_r, py_r, cx_r, cy_r;
  logic signed [COORD_BITS-1:0] bx0_r, bx1_r, by0_r, by1_r;
  logic [pbla_pkg::LEN_BITS-1:0] len_r;
  logic [pbla_pkg::CROSS_BITS-1:0] cross_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic last_r;
  logic [DB-1:0] ax_r, ay_r;
  logic [SB-1:0] sq_r, rem_r;
  logic signed [PB-1:0] p1_r, p2_r;
  logic [RB-1:0] root_r;
  logic [IB-1:0] bit_r;
  logic empty_r;
  logic signed [COORD_BITS-1:0] o_minx_r, o_maxx_r, o_miny_r, o_maxy_r;
  logic [pbla_pkg::LEN_BITS-1:0] o_len_r;
  logic [pbla_pkg::AREA_BITS-1:0] o_area_r;
  logic o_cw_r, o_cl_r;
  logic [COUNT_BITS-1:0] o_cnt_r;

  logic signed [DB-1:0] dx, dy;
  logic [2*RB-1:0] cand_sq;
  logic [RB-1:0] cand;
  logic [pbla_pkg::LEN_BITS:0] len_sum;
  logic [pbla_pkg::CROSS_BITS-1:0] total, mag;
  logic cl;

  assign q_take = q_valid && state_r == S_IDLE;
  assign dx = DB'(q_x) - DB'(px_r);
  assign dy = DB'(q_y) - DB'(py_r);
  assign cand = root_r | (RB'(1) << bit_r);
  assign cand_sq = cand * cand;
  assign len_sum = {1'b0, len_r} + (pbla_pkg::LEN_BITS + 1)'(root_r);
  assign total = cross_r + pbla_pkg::CROSS_BITS'(p1_r) - pbla_pkg::CROSS_BITS'(p2_r);
  assign mag = total[pbla_pkg::CROSS_BITS-1] ? -total : total;
  assign cl = cnt_r >= COUNT_BITS'(3) && fx_r == px_r && fy_r == py_r;

  assign empty = empty_r;
  assign min_x = o_minx_r;
  assign max_x = o_maxx_r;
  assign min_y = o_miny_r;
  assign max_y = o_maxy_r;
  assign total_length = o_len_r;
  assign twice_area = o_area_r;
  assign clockwise = o_cw_r;
  assign closed = o_cl_r;
  assign point_count = o_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      empty_r <= 1'b1;
      cnt_r <= '0;
      len_r <= '0;
      cross_r <= '0;
    end else begin
      if (pop && !empty_r && state_r != S_CLOSE) empty_r <= 1'b1;
      case (state_r)
        S_IDLE: begin
          if (q_take) begin
            last_r <= q_ctl.last;
            if (cnt_r != CMAX) cnt_r <= cnt_r + 1'b1;
            if (q_ctl.first) begin
              fx_r <= q_x; fy_r <= q_y; px_r <= q_x; py_r <= q_y;
              bx0_r <= q_x; bx1_r <= q_x; by0_r <= q_y; by1_r <= q_y;
              state_r <= q_ctl.last ? S_CLOSE : S_IDLE;
            end else begin
              ax_r <= dx[DB-1] ? DB'(-dx) : DB'(dx);
              ay_r <= dy[DB-1] ? DB'(-dy) : DB'(dy);
              cx_r <= q_x; cy_r <= q_y;
              if (q_x < bx0_r) bx0_r <= q_x;
              if (q_x > bx1_r) bx1_r <= q_x;
              if (q_y < by0_r) by0_r <= q_y;
              if (q_y > by1_r) by1_r <= q_y;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          sq_r <= SB'(ax_r) * SB'(ax_r);
          rem_r <= SB'(ay_r) * SB'(ay_r);
          p1_r <= px_r * cy_r;
          p2_r <= cx_r * py_r;
          state_r <= S_ACC;
        end
        S_ACC: begin
          sq_r <= sq_r + rem_r;
          cross_r <= cross_r + pbla_pkg::CROSS_BITS'(p1_r) - pbla_pkg::CROSS_BITS'(p2_r);
          px_r <= cx_r; py_r <= cy_r;
          root_r <= '0;
          bit_r <= IB'(RB - 1);
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (SB'(cand_sq) <= sq_r && cand_sq[2*RB-1:SB] == '0) root_r <= cand;
          if (bit_r == '0) begin
            state_r <= S_OUT;
          end else begin
            bit_r <= bit_r - 1'b1;
          end
        end
        S_OUT: begin
          len_r <= len_sum[pbla_pkg::LEN_BITS] || len_sum[pbla_pkg::LEN_BITS-1:0] == LMAX
                   ? LMAX : len_sum[pbla_pkg::LEN_BITS-1:0];
          if (last_r) begin
            p1_r <= px_r * fy_r;
            p2_r <= fx_r * py_r;
            state_r <= S_CLOSE;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_CLOSE: begin
          if (empty_r || pop) begin
            o_minx_r <= bx0_r; o_maxx_r <= bx1_r;
            o_miny_r <= by0_r; o_maxy_r <= by1_r;
            o_len_r <= len_r;
            o_cnt_r <= cnt_r;
            o_cl_r <= cl;
            o_cw_r <= cl && total[pbla_pkg::CROSS_BITS-1];
            o_area_r <= !cl ? '0 :
                        (mag[pbla_pkg::CROSS_BITS-1:pbla_pkg::AREA_BITS] != '0 ? '1 :
                         mag[pbla_pkg::AREA_BITS-1:0]);
            empty_r <= 1'b0;
            cnt_r <= '0; len_r <= '0; cross_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_IDLE && q_take && q_ctl.first && q_ctl.last) begin
        p1_r <= '0;
        p2_r <= '0;
      end
    end
  end

endmodule

// ----- sv/polyline_bbox_length_area.sv -----
// Polyline measurement: vertices enter through a one-entry queue, one at a time;
// the back end stores a first vertex as it takes it and passes each later one through
// S_MUL, S_ACC, a bit-per-cycle square root of the segment length and S_OUT;
// the last vertex then forms the result in S_CLOSE, held while an earlier result
// still waits to be popped: bounding box, saturated length sum, doubled
// shoelace area (0 unless closed), winding sense, closed flag and point count.
module polyline_bbox_length_area #(
  parameter int COORD_BITS = 24,
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] in_x_coord,
  input  logic signed [COORD_BITS-1:0] in_y_coord,
  input  logic                         in_last_point,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS-1:0] out_min_x,
  output logic signed [COORD_BITS-1:0] out_max_x,
  output logic signed [COORD_BITS-1:0] out_min_y,
  output logic signed [COORD_BITS-1:0] out_max_y,
  output logic [pbla_pkg::LEN_BITS-1:0]  out_total_length,
  output logic [pbla_pkg::AREA_BITS-1:0] out_twice_area,
  output logic                         out_clockwise,
  output logic                         out_closed,
  output logic [COUNT_BITS-1:0]        out_point_count
);

  logic                         q_valid, q_take;
  logic signed [COORD_BITS-1:0] q_x, q_y;
  pbla_pkg::ctl_t               q_ctl;

  pbla_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .x_in(in_x_coord), .y_in(in_y_coord), .last_in(in_last_point),
    .q_valid(q_valid), .q_take(q_take), .q_x(q_x), .q_y(q_y), .q_ctl(q_ctl)
  );

  pbla_back #(.COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
    .q_x(q_x), .q_y(q_y), .q_ctl(q_ctl), .empty(empty), .pop(pop),
    .min_x(out_min_x), .max_x(out_max_x), .min_y(out_min_y), .max_y(out_max_y),
    .total_length(out_total_length), .twice_area(out_twice_area),
    .clockwise(out_clockwise), .closed(out_closed), .point_count(out_point_count)
  );

endmodule

// ----- tb/polyline_bbox_length_area_tb.sv -----
module polyline_bbox_length_area_tb;

  localparam int CB = 24;
  localparam int NB = 16;
  localparam int LB = pbla_pkg::LEN_BITS;
  localparam int AB = pbla_pkg::AREA_BITS;
  localparam longint unsigned LEN_TOP = (64'd1 << LB) - 1;
  localparam longint unsigned AREA_TOP = (64'd1 << AB) - 1;
  localparam longint unsigned COUNT_TOP = (64'd1 << NB) - 1;
  localparam int STALL_LIMIT = 6000;
  localparam int LONG_HOLD = 500;

  typedef struct {
    logic signed [CB-1:0] min_x, max_x, min_y, max_y;
    logic [LB-1:0]        length;
    logic [AB-1:0]        area;
    logic                 cw;
    logic                 closed;
    logic [NB-1:0]        count;
  } meas_t;

  typedef struct {
    logic signed [CB-1:0] x, y;
    logic                 last;
    bit                   typed;
    meas_t                want;
  } vertex_t;

  logic clk = 0;
  logic rst_n = 0;
  logic push = 0;
  logic pop = 0;
  logic signed [CB-1:0] in_x_coord = '0;
  logic signed [CB-1:0] in_y_coord = '0;
  logic in_last_point = 0;
  logic full, empty;
  logic signed [CB-1:0] out_min_x, out_max_x, out_min_y, out_max_y;
  logic [LB-1:0] out_total_length;
  logic [AB-1:0] out_twice_area;
  logic out_clockwise, out_closed;
  logic [NB-1:0] out_point_count;

  polyline_bbox_length_area dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  longint first_x, first_y, prev_x, prev_y;
  longint bmin_x, bmax_x, bmin_y, bmax_y;
  longint unsigned len_acc, vcount;
  bit [63:0] cross_acc;

  vertex_t stim_q[$];
  meas_t   meas_q[$];
  int n_dir, idx, errors, n_runs, n_closed, n_vert;
  int burst_left, gap_left, idle_cycles;
  bit holding;

  function automatic longint unsigned seg_len(longint dx, longint dy);
    bit [63:0] s, r, c;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    s = dx * dx + dy * dy;
    r = 0;
    for (int b = 27; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  task automatic measure_vertex(input vertex_t v, output bit done, output meas_t m);
    longint x, y;
    longint unsigned seg;
    bit [63:0] tot, a;
    bit cl, neg;
    x = v.x;
    y = v.y;
    if (vcount == 0) begin
      first_x = x; prev_x = x; first_y = y; prev_y = y;
      bmin_x = x; bmax_x = x; bmin_y = y; bmax_y = y;
    end else begin
      seg = seg_len(x - prev_x, y - prev_y);
      len_acc = (seg >= LEN_TOP - len_acc) ? LEN_TOP : len_acc + seg;
      cross_acc = cross_acc + (prev_x * y - x * prev_y);
      if (x < bmin_x) bmin_x = x;
      if (x > bmax_x) bmax_x = x;
      if (y < bmin_y) bmin_y = y;
      if (y > bmax_y) bmax_y = y;
      prev_x = x;
      prev_y = y;
    end
    if (vcount < COUNT_TOP) vcount++;
    done = v.last;
    if (!v.last) return;
    cl = vcount >= 3 && first_x == prev_x && first_y == prev_y;
    tot = cross_acc + (prev_x * first_y - first_x * prev_y);
    neg = tot[63];
    a = neg ? -tot : tot;
    if (a > AREA_TOP) a = AREA_TOP;
    m.min_x = CB'(bmin_x); m.max_x = CB'(bmax_x);
    m.min_y = CB'(bmin_y); m.max_y = CB'(bmax_y);
    m.length = LB'(len_acc);
    m.area = cl ? AB'(a) : '0;
    m.cw = cl && neg;
    m.closed = cl;
    m.count = NB'(vcount);
    vcount = 0;
    len_acc = 0;
    cross_acc = 0;
  endtask

  function automatic meas_t lone(longint x, longint y);
    meas_t m;
    m.min_x = CB'(x); m.max_x = CB'(x); m.min_y = CB'(y); m.max_y = CB'(y);
    m.length = 0; m.area = 0; m.cw = 0; m.closed = 0; m.count = 1;
    return m;
  endfunction

  task automatic add_vtx(longint x, longint y, bit last, bit typed = 0, meas_t w = '{default: 0});
    vertex_t v;
    v.x = CB'(x); v.y = CB'(y); v.last = last; v.typed = typed; v.want = w;
    stim_q.push_back(v);
  endtask

  function automatic longint rand_coord(int mode);
    case (mode)
      0: return longint'($signed(24'($urandom)));
      1: return longint'($urandom_range(0, 200)) - 100;
      2: return ($urandom_range(0, 1)) ? 8388607 : -8388608;
      default: return longint'($urandom_range(0, 40000)) - 20000;
    endcase
  endfunction

  initial begin
    meas_t sq;
    int npts, mode;
    longint fx, fy;
    bit shut;
    add_vtx(-8388608, -8388608, 1, 1, lone(-8388608, -8388608));
    add_vtx(8388607, 8388607, 1, 1, lone(8388607, 8388607));
    add_vtx(-8388608, 8388607, 1, 1, lone(-8388608, 8388607));
    add_vtx(0, 0, 1, 1, lone(0, 0));
    sq = '{min_x: 0, max_x: 10, min_y: 0, max_y: 10, length: 40, area: 200,
           cw: 1, closed: 1, count: 5};
    add_vtx(0, 0, 0); add_vtx(0, 10, 0); add_vtx(10, 10, 0); add_vtx(10, 0, 0);
    add_vtx(0, 0, 1, 1, sq);
    // counter-clockwise extreme square
    add_vtx(-8388608, -8388608, 0); add_vtx(8388607, -8388608, 0);
    add_vtx(8388607, 8388607, 0); add_vtx(-8388608, 8388607, 0);
    add_vtx(-8388608, -8388608, 1);
    // two points, extreme diagonal
    add_vtx(-8388608, -8388608, 0); add_vtx(8388607, 8388607, 1);
    // there and back: closed, zero area
    add_vtx(5, 5, 0); add_vtx(-7, 3, 0); add_vtx(5, 5, 1);
    // first equals last with only two points: not closed
    add_vtx(3, 4, 0); add_vtx(3, 4, 1);
    // open triangle
    add_vtx(1, 1, 0); add_vtx(100, -50, 0); add_vtx(-30, 77, 1);
    n_dir = stim_q.size();
    while (stim_q.size() < 1400) begin
      npts = $urandom_range(1, 9);
      mode = $urandom_range(0, 3);
      shut = $urandom_range(0, 2) != 0;
      fx = rand_coord(mode);
      fy = rand_coord(mode);
      for (int i = 0; i < npts; i++) begin
        if (i == 0) add_vtx(fx, fy, 0);
        else add_vtx(rand_coord(mode), rand_coord(mode), $urandom_range(0, 15) == 0);
      end
      if (shut) add_vtx(fx, fy, 1);
      else stim_q[stim_q.size() - 1].last = 1;
    end
    stim_q[stim_q.size() - 1].last = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    wait (idx == stim_q.size() && meas_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d vertices (%0d directed) in %0d runs, %0d closed",
             n_vert, n_dir, n_runs, n_closed);
    if (errors == 0 && meas_q.size() == 0) $display("polyline_bbox_length_area_tb: clean");
    else $display("polyline_bbox_length_area_tb: errors");
    $finish;
  end

  // sender, bursts with gaps
  always @(posedge clk) begin
    vertex_t v;
    meas_t m;
    bit done;
    if (rst_n) begin
      if (push && !full) begin
        measure_vertex(stim_q[idx], done, m);
        if (done) meas_q.push_back(stim_q[idx].typed ? stim_q[idx].want : m);
        idx++;
        n_vert++;
      end
      if (!push || !full) begin
        if (gap_left > 0 || idx >= stim_q.size()) begin
          push <= 0;
          if (gap_left > 0) gap_left--;
        end else begin
          v = stim_q[idx];
          push <= 1;
          in_x_coord <= v.x;
          in_y_coord <= v.y;
          in_last_point <= v.last;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // receiver, with one long hold-off
  always @(posedge clk) begin
    int hold_cnt;
    meas_t w;
    if (rst_n) begin
      if (pop && !empty) begin
        n_runs++;
        if (out_closed) n_closed++;
        if (meas_q.size() == 0) begin
          $error("unexpected transaction");
          errors++;
        end else begin
          w = meas_q.pop_front();
          if (out_min_x !== w.min_x) begin
            $error("min_x exp %0d got %0d", w.min_x, out_min_x); errors++;
          end
          if (out_max_x !== w.max_x) begin
            $error("max_x exp %0d got %0d", w.max_x, out_max_x); errors++;
          end
          if (out_min_y !== w.min_y) begin
            $error("min_y exp %0d got %0d", w.min_y, out_min_y); errors++;
          end
          if (out_max_y !== w.max_y) begin
            $error("max_y exp %0d got %0d", w.max_y, out_max_y); errors++;
          end
          if (out_total_length !== w.length) begin
            $error("total_length exp %0d got %0d", w.length, out_total_length); errors++;
          end
          if (out_twice_area !== w.area) begin
            $error("twice_area exp %0d got %0d", w.area, out_twice_area); errors++;
          end
          if (out_clockwise !== w.cw) begin
            $error("clockwise exp %0d got %0d", w.cw, out_clockwise); errors++;
          end
          if (out_closed !== w.closed) begin
            $error("closed exp %0d got %0d", w.closed, out_closed); errors++;
          end
          if (out_point_count !== w.count) begin
            $error("point_count exp %0d got %0d", w.count, out_point_count); errors++;
          end
        end
      end
      if (!holding && idx > 600 && idx < 620) begin
        holding = 1;
        hold_cnt = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 0;
      end else if (idx < 200 || (idx > 900 && idx < 1100)) begin
        pop <= 1;
      end else begin
        pop <= ($urandom_range(0, 7) < 3);
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("polyline_bbox_length_area_tb: errors");
        $finish;
      end
    end
  end

endmodule
